[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[rtl/core/ljr_pkg.sv]
// types, codes and constants of the link join retry controller
package ljr_pkg;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_JOINING = 2'd1,
      MODE_UP      = 2'd2,
      MODE_AP      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_CONNECT    = 3'd1,
      ACT_RETRY      = 3'd2,
      ACT_AP         = 3'd3,
      ACT_DISCONNECT = 3'd4
   } action_type;

   localparam logic [2:0] FUNC_START       = 3'd0;
   localparam logic [2:0] FUNC_STA_START   = 3'd1;
   localparam logic [2:0] FUNC_DISCONNECT  = 3'd2;
   localparam logic [2:0] FUNC_GOT_IP      = 3'd3;
   localparam logic [2:0] FUNC_TIMER_FIRED = 3'd4;
   localparam logic [2:0] FUNC_PAUSE       = 3'd5;
   localparam logic [2:0] FUNC_RESUME      = 3'd6;

   localparam logic [1:0] CSR_KNOWN_COUNT     = 2'd0;
   localparam logic [1:0] CSR_BASE_DELAY      = 2'd1;
   localparam logic [1:0] CSR_MAX_DELAY       = 2'd2;
   localparam logic [1:0] CSR_PER_NET_RETRIES = 2'd3;

   localparam logic [3:0]  KNOWN_COUNT_RESET     = 4'd0;
   localparam logic [15:0] BASE_DELAY_RESET      = 16'd500;
   localparam logic [19:0] MAX_DELAY_RESET       = 20'd8000;
   localparam logic [7:0]  PER_NET_RETRIES_RESET = 8'd3;

   localparam logic [2:0] SHIFT_CAP = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic       no_ap_found;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [19:0] backoff;
      logic [2:0]  join_index;
      mode_type    link_state;
      logic        cancel_timer;
   } rsp_type;

   typedef struct packed {
      mode_type   link_mode;
      logic [7:0] retry_count;
      logic       ever_connected;
      logic [2:0] current_net;
      logic [3:0] pass_failures;
      logic       paused;
   } state_type;

   typedef struct packed {
      logic [3:0]  eff_count;
      logic [15:0] base_backoff;
      logic [19:0] backoff_cap;
      logic [7:0]  per_net_retries;
   } cfg_type;

   // n mod k for n up to 8; k of zero is never used on the taken path
   function automatic logic [3:0] wrap_mod(logic [3:0] n, logic [3:0] k);
      logic [3:0] r;
      r = n;
      if (k == 4'd1) begin
         r = 4'd0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (r >= k) begin
               r = r - k;
            end
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/ljr_req_stage.sv]
// input register stage for link event requests
module ljr_req_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ljr_pkg::req_type req_data,
   output logic             stage_valid,
   output ljr_pkg::req_type stage_data,
   input  logic             stage_take
);

   logic             valid_ff;
   ljr_pkg::req_type data_ff;

   assign req_ready   = !valid_ff || stage_take;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

[rtl/core/ljr_step_logic.sv]
// per event decision logic: next link state and the command for one request
module ljr_step_logic (
   input  ljr_pkg::state_type cur,
   input  ljr_pkg::cfg_type   cfg,
   input  ljr_pkg::req_type   req,
   output ljr_pkg::state_type nxt,
   output ljr_pkg::rsp_type   rsp
);

   logic [7:0]  rc_base;
   logic [7:0]  rc_bump;
   logic [3:0]  pf_bump;
   logic [3:0]  net_wrap;
   logic [2:0]  shift;
   logic [19:0] shifted;
   logic [19:0] delay;
   logic        has_nets;

   always_comb begin
      has_nets = (cfg.eff_count != 4'd0);
      rc_base  = (cur.link_mode == ljr_pkg::MODE_UP) ? 8'd0 : cur.retry_count;
      rc_bump  = (rc_base == 8'hFF) ? rc_base : rc_base + 8'd1;
      pf_bump  = (cur.pass_failures == 4'hF) ? cur.pass_failures
                                              : cur.pass_failures + 4'd1;
      net_wrap = ljr_pkg::wrap_mod({1'b0, cur.current_net} + 4'd1, cfg.eff_count);
      shift    = (rc_bump >= {5'd0, ljr_pkg::SHIFT_CAP}) ? ljr_pkg::SHIFT_CAP : rc_bump[2:0];
      shifted  = {4'd0, cfg.base_backoff} << shift;
      delay    = (shifted > cfg.backoff_cap) ? cfg.backoff_cap : shifted;
   end

   always_comb begin
      nxt              = cur;
      rsp.action       = ljr_pkg::ACT_NONE;
      rsp.backoff      = 20'd0;
      rsp.cancel_timer = 1'b0;
      case (req.func)
         ljr_pkg::FUNC_START: begin
            if (has_nets) begin
               nxt.current_net   = 3'd0;
               nxt.pass_failures = 4'd0;
               nxt.link_mode     = ljr_pkg::MODE_JOINING;
               nxt.retry_count   = 8'd0;
            end else begin
               nxt.link_mode = ljr_pkg::MODE_AP;
               rsp.action    = ljr_pkg::ACT_AP;
            end
         end
         ljr_pkg::FUNC_STA_START, ljr_pkg::FUNC_TIMER_FIRED: begin
            if (cur.link_mode == ljr_pkg::MODE_JOINING && !cur.paused) begin
               rsp.action = ljr_pkg::ACT_CONNECT;
            end
         end
         ljr_pkg::FUNC_DISCONNECT: begin
            if (!cur.paused &&
                (cur.link_mode inside {ljr_pkg::MODE_UP, ljr_pkg::MODE_JOINING})) begin
               nxt.link_mode   = ljr_pkg::MODE_JOINING;
               nxt.retry_count = rc_bump;
               if (!cur.ever_connected && (req.no_ap_found || rc_bump > cfg.per_net_retries)) begin
                  // move on to the next known network, or give up the pass and fall back to access point
                  nxt.pass_failures = pf_bump;
                  if (!has_nets || pf_bump >= cfg.eff_count) begin
                     nxt.link_mode = ljr_pkg::MODE_AP;
                     rsp.action    = ljr_pkg::ACT_AP;
                  end else begin
                     nxt.current_net = net_wrap[2:0];
                     nxt.retry_count = 8'd0;
                     rsp.action      = ljr_pkg::ACT_CONNECT;
                  end
               end else begin
                  rsp.action  = ljr_pkg::ACT_RETRY;
                  rsp.backoff = delay;
               end
            end
         end
         ljr_pkg::FUNC_GOT_IP: begin
            nxt.link_mode      = ljr_pkg::MODE_UP;
            nxt.retry_count    = 8'd0;
            nxt.pass_failures  = 4'd0;
            nxt.ever_connected = 1'b1;
         end
         ljr_pkg::FUNC_PAUSE: begin
            if (!cur.paused) begin
               nxt.paused       = 1'b1;
               rsp.cancel_timer = 1'b1;
               if (cur.link_mode == ljr_pkg::MODE_JOINING) begin
                  rsp.action = ljr_pkg::ACT_DISCONNECT;
               end
            end
         end
         ljr_pkg::FUNC_RESUME: begin
            if (cur.paused) begin
               nxt.paused = 1'b0;
               if (cur.link_mode == ljr_pkg::MODE_OFF ||
                   cur.link_mode == ljr_pkg::MODE_JOINING) begin
                  if (has_nets) begin
                     nxt.current_net   = 3'd0;
                     nxt.pass_failures = 4'd0;
                     nxt.link_mode     = ljr_pkg::MODE_JOINING;
                     nxt.retry_count   = 8'd0;
                     rsp.action        = ljr_pkg::ACT_CONNECT;
                  end else begin
                     nxt.link_mode = ljr_pkg::MODE_AP;
                     rsp.action    = ljr_pkg::ACT_AP;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp.join_index = nxt.current_net;
      rsp.link_state = nxt.link_mode;
   end

endmodule

[rtl/core/link_join_retry_controller.sv]
// top level of the link join retry controller: csr registers, link state and result register
// One request per clock cycle, sustained: every event is decided by one pass of
// small compare, shift and update logic between the request register and the
// result register, so a request in the request register loads the result register
// as soon as that is free, and a new request is taken each cycle while rsp_ready
// stays high. A result waiting on rsp_ready holds the next request in the request
// register, and req_ready drops once that register is full too, so at most two
// requests sit inside the block. The user must write the csr registers (known count,
// base delay, delay cap, per-network retries) only while no request is in flight;
// the block itself does not enforce it. Known counts above MAX_KNOWN act as MAX_KNOWN.
module link_join_retry_controller #(
   parameter int MAX_KNOWN = 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  ljr_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ljr_pkg::rsp_type rsp_data,
   // csr write port
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [19:0]      csr_wdata
);

   // csr registers
   logic [3:0]  known_count_ff;
   logic [15:0] base_delay_ff;
   logic [19:0] max_delay_ff;
   logic [7:0]  per_net_retries_ff;
   ljr_pkg::cfg_type cfg;

   // link state
   ljr_pkg::state_type state_ff;
   ljr_pkg::state_type state_in;

   // result register
   logic             rsp_valid_ff;
   ljr_pkg::rsp_type rsp_data_ff;
   ljr_pkg::rsp_type rsp_data_in;

   // request register outputs
   logic             stage_valid;
   ljr_pkg::req_type stage_data;
   logic             stage_take;
   logic             fire;

   // the result register frees up when empty or being taken this cycle
   assign stage_take = !rsp_valid_ff || rsp_ready;
   assign fire       = stage_valid && stage_take;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // clamp the known count to the hardware limit
   always_comb begin
      cfg.eff_count       = (int'(known_count_ff) > MAX_KNOWN) ? 4'(MAX_KNOWN) : known_count_ff;
      cfg.base_backoff    = base_delay_ff;
      cfg.backoff_cap     = max_delay_ff;
      cfg.per_net_retries = per_net_retries_ff;
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         known_count_ff     <= ljr_pkg::KNOWN_COUNT_RESET;
         base_delay_ff      <= ljr_pkg::BASE_DELAY_RESET;
         max_delay_ff       <= ljr_pkg::MAX_DELAY_RESET;
         per_net_retries_ff <= ljr_pkg::PER_NET_RETRIES_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ljr_pkg::CSR_KNOWN_COUNT:     known_count_ff     <= csr_wdata[3:0];
            ljr_pkg::CSR_BASE_DELAY:      base_delay_ff      <= csr_wdata[15:0];
            ljr_pkg::CSR_MAX_DELAY:       max_delay_ff       <= csr_wdata;
            ljr_pkg::CSR_PER_NET_RETRIES: per_net_retries_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // request register
   ljr_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take)
   );

   // event decision
   ljr_step_logic u_step_logic (
      .cur (state_ff),
      .cfg (cfg),
      .req (stage_data),
      .nxt (state_in),
      .rsp (rsp_data_in)
   );

   // link state advances once per decided request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.link_mode      <= ljr_pkg::MODE_OFF;
         state_ff.retry_count    <= 8'd0;
         state_ff.ever_connected <= 1'b0;
         state_ff.current_net    <= 3'd0;
         state_ff.pass_failures  <= 4'd0;
         state_ff.paused         <= 1'b0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register: loads on fire, empties when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[rtl/core/ljr_checker.sv]
// port level checker for the link join retry controller, with its bind
`include "assert_macros.svh"

module ljr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ljr_pkg::rsp_type rsp_data
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
   `ASSERT_NEVER(a_delay_only_retry, clock, reset, rsp_valid && rsp_data.action != ljr_pkg::ACT_RETRY && rsp_data.backoff != 20'd0, "delay given without a retry")
   `ASSERT_NEVER(a_connect_joining, clock, reset, rsp_valid && rsp_data.action == ljr_pkg::ACT_CONNECT && rsp_data.link_state != ljr_pkg::MODE_JOINING, "connect outside joining")
   `ASSERT_NEVER(a_ap_mode, clock, reset, rsp_valid && rsp_data.action == ljr_pkg::ACT_AP && rsp_data.link_state != ljr_pkg::MODE_AP, "access point command without access point mode")
   `ASSERT_NEVER(a_cancel_pause, clock, reset, rsp_valid && rsp_data.cancel_timer && rsp_data.action != ljr_pkg::ACT_NONE && rsp_data.action != ljr_pkg::ACT_DISCONNECT, "timer cancel with a join command")

endmodule

bind link_join_retry_controller ljr_checker u_ljr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[bench/testbench.sv]
// self-checking testbench for the link join retry controller
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_KNOWN = 8;
   // event code the block must answer with none and no state change
   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   // generous bound: every request with a full sender gap and a full receiver stall
   localparam int CYCLE_LIMIT = 400000;
   // receiver back-pressure long enough to fill the block and stall requests
   localparam int LONG_HOLD_CYCLES = 150;
   // cycles to let pass once nothing is outstanding
   localparam int DRAIN_CYCLES = 8;

   // one line of the directed script: either a csr write or a request
   typedef struct {
      bit               is_csr;
      logic [1:0]       csr_idx;
      logic [19:0]      csr_val;
      ljr_pkg::req_type req;
      bit               pinned;   // command typed in by hand instead of predicted
      ljr_pkg::rsp_type want;
   } step_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ljr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ljr_pkg::rsp_type rsp_data;
   logic             csr_write_en = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [19:0]      csr_wdata = '0;

   // shadow of the csr registers, raw as written
   logic [3:0]  known_cfg = ljr_pkg::KNOWN_COUNT_RESET;
   logic [15:0] base_cfg = ljr_pkg::BASE_DELAY_RESET;
   logic [19:0] max_cfg = ljr_pkg::MAX_DELAY_RESET;
   logic [7:0]  per_net_cfg = ljr_pkg::PER_NET_RETRIES_RESET;

   // predicted link state; all-zero is the state after reset
   ljr_pkg::state_type link_st = '0;

   ljr_pkg::rsp_type pending_commands[$];
   int               mismatch_count = 0;
   step_row_type     script[$];

   // stimulus shaping, shared between the sender and the receiver
   bit sender_gaps = 1'b1;
   bit quiet_tail = 1'b0;
   bit long_hold_wanted = 1'b0;

   link_join_retry_controller #(
      .MAX_KNOWN(MAX_KNOWN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // synchronous reset, asserted from time zero and never raised again
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // command predictor: applies one link event to the shadow state and returns
   // the command the block must answer with
   // ---------------------------------------------------------------------------
   function automatic ljr_pkg::rsp_type predict_command(ljr_pkg::req_type ev);
      ljr_pkg::rsp_type r;
      logic [3:0]       k;
      logic [31:0]      wide;
      int               shift;
      r.action = ljr_pkg::ACT_NONE;
      r.backoff = '0;
      r.cancel_timer = 1'b0;
      // counts above the table size act as the table size
      k = (known_cfg > 4'(MAX_KNOWN)) ? 4'(MAX_KNOWN) : known_cfg;
      case (ev.func)
         ljr_pkg::FUNC_START: begin
            // works in any state and ignores pause
            if (k != 4'd0) begin
               link_st.current_net = '0;
               link_st.pass_failures = '0;
               link_st.link_mode = ljr_pkg::MODE_JOINING;
               link_st.retry_count = '0;
            end else begin
               link_st.link_mode = ljr_pkg::MODE_AP;
               r.action = ljr_pkg::ACT_AP;
            end
         end
         ljr_pkg::FUNC_STA_START, ljr_pkg::FUNC_TIMER_FIRED: begin
            if (link_st.link_mode == ljr_pkg::MODE_JOINING && !link_st.paused) begin
               r.action = ljr_pkg::ACT_CONNECT;
            end
         end
         ljr_pkg::FUNC_DISCONNECT: begin
            if (!link_st.paused) begin
               // a dropped link goes back to joining with a fresh retry count
               if (link_st.link_mode == ljr_pkg::MODE_UP) begin
                  link_st.link_mode = ljr_pkg::MODE_JOINING;
                  link_st.retry_count = '0;
               end
               if (link_st.link_mode == ljr_pkg::MODE_JOINING) begin
                  if (link_st.retry_count != 8'hFF) link_st.retry_count++;
                  if (!link_st.ever_connected &&
                      (ev.no_ap_found || link_st.retry_count > per_net_cfg)) begin
                     // move on to the next known network, or give up the pass
                     if (link_st.pass_failures != 4'hF) link_st.pass_failures++;
                     if (k == 4'd0 || link_st.pass_failures >= k) begin
                        link_st.link_mode = ljr_pkg::MODE_AP;
                        r.action = ljr_pkg::ACT_AP;
                     end else begin
                        link_st.current_net = 3'((int'(link_st.current_net) + 1) % int'(k));
                        link_st.link_mode = ljr_pkg::MODE_JOINING;
                        link_st.retry_count = '0;
                        r.action = ljr_pkg::ACT_CONNECT;
                     end
                  end else begin
                     // back-off doubles up to four times, then the cap applies
                     shift = (link_st.retry_count < 8'(ljr_pkg::SHIFT_CAP)) ?
                             int'(link_st.retry_count) : int'(ljr_pkg::SHIFT_CAP);
                     wide = {16'h0, base_cfg} << shift;
                     r.action = ljr_pkg::ACT_RETRY;
                     r.backoff = (wide > {12'h0, max_cfg}) ? max_cfg : wide[19:0];
                  end
               end
            end
         end
         ljr_pkg::FUNC_GOT_IP: begin
            link_st.link_mode = ljr_pkg::MODE_UP;
            link_st.retry_count = '0;
            link_st.pass_failures = '0;
            link_st.ever_connected = 1'b1;
         end
         ljr_pkg::FUNC_PAUSE: begin
            if (!link_st.paused) begin
               link_st.paused = 1'b1;
               r.cancel_timer = 1'b1;
               if (link_st.link_mode == ljr_pkg::MODE_JOINING) begin
                  r.action = ljr_pkg::ACT_DISCONNECT;
               end
            end
         end
         ljr_pkg::FUNC_RESUME: begin
            if (link_st.paused) begin
               link_st.paused = 1'b0;
               // a connected link or an access point is left alone
               if (link_st.link_mode != ljr_pkg::MODE_UP &&
                   link_st.link_mode != ljr_pkg::MODE_AP) begin
                  if (k != 4'd0) begin
                     link_st.current_net = '0;
                     link_st.pass_failures = '0;
                     link_st.link_mode = ljr_pkg::MODE_JOINING;
                     link_st.retry_count = '0;
                     r.action = ljr_pkg::ACT_CONNECT;
                  end else begin
                     link_st.link_mode = ljr_pkg::MODE_AP;
                     r.action = ljr_pkg::ACT_AP;
                  end
               end
            end
         end
         default: ;
      endcase
      r.join_index = link_st.current_net;
      r.link_state = link_st.link_mode;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // result checker: every accepted command against the oldest prediction
   // ---------------------------------------------------------------------------
   function automatic void check_field(string field, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      ljr_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_commands.size() == 0) begin
            $error("command with no request outstanding: action %0d", rsp_data.action);
            mismatch_count++;
         end else begin
            want = pending_commands.pop_front();
            check_field("action", want.action, rsp_data.action);
            check_field("backoff", want.backoff, rsp_data.backoff);
            check_field("join_index", want.join_index, rsp_data.join_index);
            check_field("link_state", want.link_state, rsp_data.link_state);
            check_field("cancel_timer", want.cancel_timer, rsp_data.cancel_timer);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: random stall bursts, calm stretches, one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      int calm_left;
      calm_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_wanted) begin
            // hold results back so the block fills and stops taking requests
            long_hold_wanted = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (quiet_tail || calm_left > 0) begin
            if (calm_left > 0) calm_left--;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(30, 80);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // offer one request, hold it until taken, then record its expected command
   task automatic send_event(ljr_pkg::req_type ev, bit pinned, ljr_pkg::rsp_type pin_value);
      ljr_pkg::rsp_type predicted;
      if (!quiet_tail && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = predict_command(ev);
      pending_commands.push_back(pinned ? pin_value : predicted);
   endtask

   // stop offering and let every outstanding command come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [19:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         ljr_pkg::CSR_KNOWN_COUNT:     known_cfg = val[3:0];
         ljr_pkg::CSR_BASE_DELAY:      base_cfg = val[15:0];
         ljr_pkg::CSR_MAX_DELAY:       max_cfg = val;
         ljr_pkg::CSR_PER_NET_RETRIES: per_net_cfg = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(int known, int base, int cap, int per_net);
      wait_idle();
      write_csr(ljr_pkg::CSR_KNOWN_COUNT, 20'(known));
      write_csr(ljr_pkg::CSR_BASE_DELAY, 20'(base));
      write_csr(ljr_pkg::CSR_MAX_DELAY, 20'(cap));
      write_csr(ljr_pkg::CSR_PER_NET_RETRIES, 20'(per_net));
   endtask

   // mostly realistic settings, with the extremes drawn now and then
   task automatic random_config();
      int known, base, cap, per_net, sel;
      known = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      sel = $urandom_range(0, 3);
      base = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(1, 2000);
      sel = $urandom_range(0, 3);
      cap = (sel == 0) ? 0 : (sel == 1) ? 1048575 : $urandom_range(1, 20000);
      sel = $urandom_range(0, 3);
      per_net = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 4);
      set_config(known, base, cap, per_net);
   endtask

   function automatic ljr_pkg::req_type make_req(logic [2:0] func, logic no_ap);
      ljr_pkg::req_type ev;
      ev.func = func;
      ev.no_ap_found = no_ap;
      return ev;
   endfunction

   // event mix weighted toward join / drop / timer traffic, with a noise slice
   function automatic ljr_pkg::req_type random_event(bit allow_ip);
      ljr_pkg::req_type ev;
      int               pick;
      pick = $urandom_range(0, 99);
      ev.no_ap_found = ($urandom_range(0, 3) == 0);
      if (pick < 6) ev.func = ljr_pkg::FUNC_START;
      else if (pick < 15) ev.func = ljr_pkg::FUNC_STA_START;
      else if (pick < 55) ev.func = ljr_pkg::FUNC_DISCONNECT;
      else if (pick < 62) ev.func = allow_ip ? ljr_pkg::FUNC_GOT_IP : ljr_pkg::FUNC_TIMER_FIRED;
      else if (pick < 75) ev.func = ljr_pkg::FUNC_TIMER_FIRED;
      else if (pick < 83) ev.func = ljr_pkg::FUNC_PAUSE;
      else if (pick < 91) ev.func = ljr_pkg::FUNC_RESUME;
      else ev.func = 3'($urandom_range(0, 7));
      // an early address would end the network walk for the rest of the run
      if (!allow_ip && ev.func == ljr_pkg::FUNC_GOT_IP) ev.func = FUNC_UNUSED;
      return ev;
   endfunction

   task automatic run_phase(int count, bit allow_ip);
      for (int i = 0; i < count; i++) send_event(random_event(allow_ip), 1'b0, '0);
   endtask

   // directed script rows
   function automatic step_row_type csr_row(logic [1:0] idx, logic [19:0] val);
      step_row_type r;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      r.req = '0;
      r.pinned = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic step_row_type ev_row(logic [2:0] func, logic no_ap);
      step_row_type r;
      r.is_csr = 1'b0;
      r.csr_idx = '0;
      r.csr_val = '0;
      r.req = make_req(func, no_ap);
      r.pinned = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic step_row_type pin_row(logic [2:0] func, logic no_ap,
                                            ljr_pkg::action_type act, logic [19:0] delay,
                                            logic [2:0] idx, ljr_pkg::mode_type mode,
                                            logic cancel);
      step_row_type r;
      r = ev_row(func, no_ap);
      r.pinned = 1'b1;
      r.want.action = act;
      r.want.backoff = delay;
      r.want.join_index = idx;
      r.want.link_state = mode;
      r.want.cancel_timer = cancel;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      // fresh out of reset, default registers, no known networks
      script.push_back(pin_row(ljr_pkg::FUNC_STA_START, 1'b0, ljr_pkg::ACT_NONE, 20'd0, 3'd0,
                               ljr_pkg::MODE_OFF, 1'b0));
      script.push_back(pin_row(FUNC_UNUSED, 1'b1, ljr_pkg::ACT_NONE, 20'd0, 3'd0,
                               ljr_pkg::MODE_OFF, 1'b0));
      script.push_back(pin_row(ljr_pkg::FUNC_DISCONNECT, 1'b1, ljr_pkg::ACT_NONE, 20'd0, 3'd0,
                               ljr_pkg::MODE_OFF, 1'b0));
      script.push_back(pin_row(ljr_pkg::FUNC_PAUSE, 1'b0, ljr_pkg::ACT_NONE, 20'd0, 3'd0,
                               ljr_pkg::MODE_OFF, 1'b1));
      // second pause is ignored, no timer cancel
      script.push_back(pin_row(ljr_pkg::FUNC_PAUSE, 1'b1, ljr_pkg::ACT_NONE, 20'd0, 3'd0,
                               ljr_pkg::MODE_OFF, 1'b0));
      // resume and start with no networks fall back to access point
      script.push_back(pin_row(ljr_pkg::FUNC_RESUME, 1'b0, ljr_pkg::ACT_AP, 20'd0, 3'd0,
                               ljr_pkg::MODE_AP, 1'b0));
      script.push_back(pin_row(ljr_pkg::FUNC_START, 1'b1, ljr_pkg::ACT_AP, 20'd0, 3'd0,
                               ljr_pkg::MODE_AP, 1'b0));
      // three networks, one retry each, widest delays
      script.push_back(csr_row(ljr_pkg::CSR_KNOWN_COUNT, 20'd3));
      script.push_back(csr_row(ljr_pkg::CSR_PER_NET_RETRIES, 20'd1));
      script.push_back(csr_row(ljr_pkg::CSR_BASE_DELAY, 20'd65535));
      script.push_back(csr_row(ljr_pkg::CSR_MAX_DELAY, 20'hFFFFF));
      script.push_back(ev_row(ljr_pkg::FUNC_START, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_STA_START, 1'b1));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b0));
      // retry budget used up, then missing access point: walk the list
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b1));
      // whole pass failed
      script.push_back(pin_row(ljr_pkg::FUNC_DISCONNECT, 1'b1, ljr_pkg::ACT_AP, 20'd0, 3'd2,
                               ljr_pkg::MODE_AP, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_START, 1'b0));
      // count dropped to zero while joining
      script.push_back(csr_row(ljr_pkg::CSR_KNOWN_COUNT, 20'd0));
      script.push_back(pin_row(ljr_pkg::FUNC_DISCONNECT, 1'b1, ljr_pkg::ACT_AP, 20'd0, 3'd0,
                               ljr_pkg::MODE_AP, 1'b0));
      // count above the table size, then shrunk under the current index
      script.push_back(csr_row(ljr_pkg::CSR_KNOWN_COUNT, 20'd15));
      script.push_back(ev_row(ljr_pkg::FUNC_START, 1'b1));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b1));
      script.push_back(csr_row(ljr_pkg::CSR_KNOWN_COUNT, 20'd1));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b1));
      // connect once, then back-off doubling into the shift cap
      script.push_back(ev_row(ljr_pkg::FUNC_START, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_GOT_IP, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b1));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_DISCONNECT, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_TIMER_FIRED, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_PAUSE, 1'b0));
      script.push_back(ev_row(ljr_pkg::FUNC_RESUME, 1'b0));
      // delay clipped by the cap
      script.push_back(csr_row(ljr_pkg::CSR_MAX_DELAY, 20'd1000));
      script.push_back(pin_row(ljr_pkg::FUNC_DISCONNECT, 1'b0, ljr_pkg::ACT_RETRY, 20'd1000,
                               3'd0, ljr_pkg::MODE_JOINING, 1'b0));

      while (reset) @(posedge clock);
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            wait_idle();
            write_csr(script[i].csr_idx, script[i].csr_val);
         end else begin
            send_event(script[i].req, script[i].pinned, script[i].want);
         end
      end

      // network walk phases: address events are held back, though the script has already connected once
      for (int p = 0; p < 9; p++) begin
         if (p == 0) set_config(8, 0, 0, 0);
         else if (p == 1) set_config(15, 65535, 1048575, 255);
         else random_config();
         sender_gaps = ($urandom_range(0, 3) != 0);
         if (p == 3) begin
            // keep offering requests while the receiver holds off
            sender_gaps = 1'b0;
            long_hold_wanted = 1'b1;
         end
         run_phase(70, 1'b0);
      end

      // long drop storm after connecting: retry count runs into saturation
      set_config(8, 1, 1048575, 255);
      sender_gaps = 1'b1;
      send_event(make_req(ljr_pkg::FUNC_PAUSE, 1'b0), 1'b0, '0);
      send_event(make_req(ljr_pkg::FUNC_RESUME, 1'b0), 1'b0, '0);
      send_event(make_req(ljr_pkg::FUNC_GOT_IP, 1'b0), 1'b0, '0);
      for (int i = 0; i < 280; i++) begin
         send_event(make_req(ljr_pkg::FUNC_DISCONNECT, 1'($urandom_range(0, 1))), 1'b0, '0);
      end

      // connected-forever phases
      for (int p = 0; p < 5; p++) begin
         random_config();
         sender_gaps = ($urandom_range(0, 3) != 0);
         run_phase(70, 1'b1);
      end

      // full-rate tail, no idling on either side
      random_config();
      quiet_tail = 1'b1;
      run_phase(150, 1'b1);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ljr_pkg.sv
rtl/core/ljr_req_stage.sv
rtl/core/ljr_step_logic.sv
rtl/core/link_join_retry_controller.sv
rtl/core/ljr_checker.sv
bench/testbench.sv
